// ===== design/gscc_pkg.sv =====
package gscc_pkg;

	localparam int unsigned MaxCells  = 1048576;
	localparam int unsigned MaxSide   = 4096;
	localparam int unsigned AddrW     = $clog2(MaxCells);
	localparam int unsigned SideW     = 13;
	localparam int unsigned CoordW    = 32;
	localparam int unsigned BlockCost = 253;

	typedef logic [AddrW-1:0]  addr_t;
	typedef logic [SideW-1:0]  side_t;
	typedef logic [1:0]        outcome_t;

	localparam outcome_t OutWrite   = 2'd0;
	localparam outcome_t OutClear   = 2'd1;
	localparam outcome_t OutBadEnd  = 2'd2;
	localparam outcome_t OutBlocked = 2'd3;

	localparam logic OpWrite = 1'b0;
	localparam logic OpQuery = 1'b1;

	localparam logic CfgColumns = 1'b0;
	localparam logic CfgRows    = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_PREP,
		ST_RD_END,
		ST_CHK_END,
		ST_RD_CUR,
		ST_CHK_CUR,
		ST_CROSS,
		ST_RD_SIDE,
		ST_CHK_SIDE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                op;
		logic [19:0]         cell_index;
		logic [7:0]          cost;
		logic signed [31:0]  from_x;
		logic signed [31:0]  from_y;
		logic signed [31:0]  to_x;
		logic signed [31:0]  to_y;
	} req_t;

	typedef struct packed {
		logic [1:0] outcome;
	} rsp_t;

endpackage

// ===== design/gscc_if.sv =====
interface gscc_req_if;
	logic            valid;
	logic            ready;
	gscc_pkg::req_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface gscc_rsp_if;
	logic            valid;
	logic            ready;
	gscc_pkg::rsp_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== design/grid_segment_collision_check.sv =====
// Occupancy-grid segment checker.
// Channels: req (sink) carries one item: a cell write (op 0) or a segment
// query (op 1); rsp (source) returns one outcome item per request.
// cfg: cfg_we/cfg_idx/cfg_data write grid_columns (0) and grid_rows (1);
// values above 4096 saturate.  Write only while idle.
// Free map: one 1 Mbit synchronous RAM with one write port and one read
// port whose output is registered.
// A write item goes from ST_MUL straight to ST_DONE.  A query first checks
// both endpoint cells, then reads, checks and steps for each visited cell,
// with two side reads for each exact corner crossing; the last cell ends
// at its check and ST_DONE posts the result, while a query with an
// endpoint outside the grid stops at ST_PREP.  The walk is bounded by
// columns + rows + 3 visits.  One item is in flight at a time.
// Cell addresses y*columns+x come from one 13x13 multiply per access that
// drives the RAM read address; the address is also registered for the store
// bound check.
// Reset: clears control state and sets both sides to 3; the map content is
// undefined until written.
// Stall: the result waits in an output register; the next item is taken
// only in the cycle after the result has left.
module grid_segment_collision_check (
	input  logic                 clk,
	input  logic                 arst_n,
	gscc_req_if.sink             req,
	gscc_rsp_if.source           rsp,
	input  logic                 cfg_we,
	input  logic                 cfg_idx,
	input  logic [12:0]          cfg_data
);

	gscc_pkg::state_t state_q, state_d;
	gscc_pkg::side_t  cols_q, rows_q;
	gscc_pkg::req_t   r_q;

	// walk state
	logic signed [19:0] x_q, y_q, ex_q, ey_q;
	logic signed [1:0]  sx_q, sy_q;
	logic [27:0]        adx_q, ady_q;
	logic [27:0]        nx_q, ny_q;
	logic [14:0]        steps_q;
	logic               pend_q;  // which endpoint/side being checked
	logic [55:0]        lhs_q, rhs_q;
	logic [1:0]         outc_q;
	logic               ovalid_q;

	// cell address pipeline
	logic signed [19:0] cx_q, cy_q;
	logic               cin_s1;
	logic [25:0]        addr_d;
	logic [25:0]        addr_s1;

	// RAM
	logic               mem_q [gscc_pkg::MaxCells];
	logic               rd_q;
	logic               mem_we;
	gscc_pkg::addr_t    mem_wa;

	logic signed [32:0] dx, dy;
	logic cur_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= 13'd3;
			rows_q <= 13'd3;
		end else if (cfg_we) begin
			if (cfg_idx == gscc_pkg::CfgColumns)
				cols_q <= (cfg_data > 13'd4096) ? 13'd4096 : cfg_data;
			else
				rows_q <= (cfg_data > 13'd4096) ? 13'd4096 : cfg_data;
		end
	end

	// address stage: cx_q/cy_q set by the FSM; the RAM read and the bound
	// flags land together in the following cycle
	assign addr_d = 26'(cy_q[12:0] * cols_q) + 26'(cx_q[12:0]);

	always_ff @(posedge clk) begin
		cin_s1  <= !cx_q[19] && !cy_q[19] && (cx_q < $signed({7'd0, cols_q}))
			&& (cy_q < $signed({7'd0, rows_q}));
		addr_s1 <= addr_d;
	end

	assign mem_we = (state_q == gscc_pkg::ST_MUL) && (r_q.op == gscc_pkg::OpWrite);
	assign mem_wa = r_q.cell_index;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[mem_wa] <= (r_q.cost < 8'(gscc_pkg::BlockCost));
		rd_q <= mem_q[addr_d[gscc_pkg::AddrW-1:0]];
	end

	// a cell is free only inside the grid and inside the store
	assign cur_ok = cin_s1 && (addr_s1 < 26'(gscc_pkg::MaxCells)) && rd_q;

	assign dx = 33'(r_q.to_x) - 33'(r_q.from_x);
	assign dy = 33'(r_q.to_y) - 33'(r_q.from_y);

	function automatic logic pt_in(input logic signed [31:0] p, input gscc_pkg::side_t n);
		return !p[31] && ({16'd0, p[31:16]} < {19'd0, n});
	endfunction

	assign req.ready = (state_q == gscc_pkg::ST_IDLE) && !ovalid_q;
	assign rsp.valid = ovalid_q;
	assign rsp.data.outcome = outc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= gscc_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	logic xinf, yinf;
	assign xinf = (sx_q == 2'sd0) || (x_q == ex_q);
	assign yinf = (sy_q == 2'sd0) || (y_q == ey_q);

	// exact corner crossing: both side cells are read before the diagonal step
	logic corner;
	assign corner = !xinf && !yinf && (lhs_q == rhs_q);

	logic finish;
	logic [1:0] fin_code;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gscc_pkg::ST_IDLE:     if (req.valid && req.ready) state_d = gscc_pkg::ST_MUL;
			gscc_pkg::ST_MUL:      state_d = (r_q.op == gscc_pkg::OpWrite) ? gscc_pkg::ST_DONE
				: gscc_pkg::ST_PREP;
			gscc_pkg::ST_PREP:     state_d = gscc_pkg::ST_RD_END;
			gscc_pkg::ST_RD_END:   state_d = gscc_pkg::ST_CHK_END;
			gscc_pkg::ST_CHK_END:  state_d = pend_q ? gscc_pkg::ST_RD_END : gscc_pkg::ST_RD_CUR;
			gscc_pkg::ST_RD_CUR:   state_d = gscc_pkg::ST_CHK_CUR;
			gscc_pkg::ST_CHK_CUR:  state_d = gscc_pkg::ST_CROSS;
			gscc_pkg::ST_CROSS:    state_d = corner ? gscc_pkg::ST_RD_SIDE : gscc_pkg::ST_RD_CUR;
			gscc_pkg::ST_RD_SIDE:  state_d = gscc_pkg::ST_CHK_SIDE;
			gscc_pkg::ST_CHK_SIDE: state_d = pend_q ? gscc_pkg::ST_RD_SIDE : gscc_pkg::ST_RD_CUR;
			gscc_pkg::ST_DONE:     state_d = gscc_pkg::ST_IDLE;
			default:               state_d = gscc_pkg::ST_IDLE;
		endcase
		// early exits flagged by the finish logic override
		if (finish) state_d = gscc_pkg::ST_DONE;
	end

	always_comb begin
		finish = 1'b0;
		fin_code = gscc_pkg::OutClear;
		unique case (state_q)
			gscc_pkg::ST_PREP: begin
				if (!(pt_in(r_q.from_x, cols_q) && pt_in(r_q.from_y, rows_q)
						&& pt_in(r_q.to_x, cols_q) && pt_in(r_q.to_y, rows_q))) begin
					finish = 1'b1; fin_code = gscc_pkg::OutBadEnd;
				end
			end
			gscc_pkg::ST_CHK_END: if (!cur_ok) begin
				finish = 1'b1; fin_code = gscc_pkg::OutBadEnd;
			end
			gscc_pkg::ST_CHK_CUR: begin
				if (!cur_ok) begin
					finish = 1'b1; fin_code = gscc_pkg::OutBlocked;
				end else if (x_q == ex_q && y_q == ey_q) begin
					finish = 1'b1; fin_code = gscc_pkg::OutClear;
				end
			end
			gscc_pkg::ST_CHK_SIDE: if (!cur_ok) begin
				finish = 1'b1; fin_code = gscc_pkg::OutBlocked;
			end
			gscc_pkg::ST_RD_CUR: if (steps_q == 15'(cols_q) + 15'(rows_q) + 15'd3) begin
				finish = 1'b1; fin_code = gscc_pkg::OutBlocked;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			outc_q   <= gscc_pkg::OutWrite;
		end else begin
			if (rsp.valid && rsp.ready) ovalid_q <= 1'b0;
			if (state_q == gscc_pkg::ST_DONE) ovalid_q <= 1'b1;
			if (finish) outc_q <= fin_code;
			else if (state_q == gscc_pkg::ST_MUL) outc_q <= gscc_pkg::OutWrite;
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			gscc_pkg::ST_IDLE: if (req.valid && req.ready) r_q <= req.data;
			gscc_pkg::ST_MUL: begin
				x_q  <= 20'(r_q.from_x >>> 16);
				y_q  <= 20'(r_q.from_y >>> 16);
				ex_q <= 20'(r_q.to_x >>> 16);
				ey_q <= 20'(r_q.to_y >>> 16);
				sx_q <= (dx == 33'sd0) ? 2'sd0 : (dx[32] ? -2'sd1 : 2'sd1);
				sy_q <= (dy == 33'sd0) ? 2'sd0 : (dy[32] ? -2'sd1 : 2'sd1);
				// both endpoints lie below 4096 cells when the walk runs: 28 bits
				adx_q <= dx[32] ? 28'(-dx) : 28'(dx);
				ady_q <= dy[32] ? 28'(-dy) : 28'(dy);
				// distance to next boundary (endpoints are non-negative when used)
				nx_q <= dx[32] ? 28'({r_q.from_x[15:0]})
					: 28'(17'h10000 - 17'(r_q.from_x[15:0]));
				ny_q <= dy[32] ? 28'({r_q.from_y[15:0]})
					: 28'(17'h10000 - 17'(r_q.from_y[15:0]));
				steps_q <= '0;
				pend_q  <= 1'b1;
			end
			gscc_pkg::ST_PREP: begin
				cx_q <= x_q; cy_q <= y_q;
			end
			gscc_pkg::ST_RD_END: ;
			gscc_pkg::ST_CHK_END: begin
				pend_q <= 1'b0;
				cx_q <= pend_q ? ex_q : x_q;
				cy_q <= pend_q ? ey_q : y_q;
			end
			gscc_pkg::ST_RD_CUR: begin
				steps_q <= steps_q + 15'd1;
				// nx never exceeds adx while the x step is still open, so 28x28
				lhs_q <= 56'(nx_q) * 56'(ady_q);
				rhs_q <= 56'(ny_q) * 56'(adx_q);
			end
			gscc_pkg::ST_CHK_CUR: ;
			gscc_pkg::ST_CROSS: begin
				if (!xinf && !yinf && lhs_q == rhs_q) begin
					cx_q <= x_q + 20'(sx_q); cy_q <= y_q;
					pend_q <= 1'b1;
				end else if (!xinf && (yinf || lhs_q < rhs_q)) begin
					x_q <= x_q + 20'(sx_q); nx_q <= nx_q + 28'h10000;
					cx_q <= x_q + 20'(sx_q); cy_q <= y_q;
				end else begin
					y_q <= y_q + 20'(sy_q); ny_q <= ny_q + 28'h10000;
					cx_q <= x_q; cy_q <= y_q + 20'(sy_q);
				end
			end
			gscc_pkg::ST_RD_SIDE: ;
			gscc_pkg::ST_CHK_SIDE: begin
				if (pend_q) begin
					pend_q <= 1'b0;
					cx_q <= x_q; cy_q <= y_q + 20'(sy_q);
				end else begin
					x_q <= x_q + 20'(sx_q); y_q <= y_q + 20'(sy_q);
					nx_q <= nx_q + 28'h10000; ny_q <= ny_q + 28'h10000;
					cx_q <= x_q + 20'(sx_q); cy_q <= y_q + 20'(sy_q);
				end
			end
			gscc_pkg::ST_DONE: ;
			default: ;
		endcase
	end

endmodule

// ===== design/gscc_checker.sv =====
module gscc_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [1:0] outcome
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(outcome))
		else $error("result changed while stalled");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("item taken while result pending");

	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !rsp_valid)
		else $error("result too early");

	a_next_wait: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second item taken in flight");

endmodule

bind grid_segment_collision_check gscc_checker u_gscc_checker (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.outcome(rsp.data.outcome)
);

// ===== sim/grid_segment_collision_check_test.sv =====
module grid_segment_collision_check_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint OneCell = 65536;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_idx;
	logic [12:0] cfg_data;

	gscc_req_if req_ch ();
	gscc_rsp_if rsp_ch ();

	grid_segment_collision_check DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// Our own view of the block: grid size and the free map, plus a record of
	// which cells have been written so that no query ever reads one that has not.
	longint grid_cols;
	longint grid_rows;
	bit cell_is_free [gscc_pkg::MaxCells];
	bit cell_written [gscc_pkg::MaxCells];
	bit touched_unwritten;

	gscc_pkg::outcome_t expected_outcomes [$];
	int unsigned failures;

	// Sender burst state: items left in the current burst.
	int unsigned burst_left;

	// Receiver stall pattern state.
	int unsigned stall_left;
	int unsigned stall_mode;
	logic [7:0] stall_mask;
	int unsigned stall_phase;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Generous cap on the whole run; a correct run needs a fraction of it.
	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end

	task automatic report_mismatch(string what);
		failures++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// ---------------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------------

	// Free test of one grid cell. Cells off the grid or beyond the store read
	// blocked without touching the map; anything else is a real map read.
	function automatic bit cell_open(longint x, longint y);
		longint addr;
		if (x < 0 || y < 0 || x >= grid_cols || y >= grid_rows)
			return 1'b0;
		addr = y * grid_cols + x;
		if (addr >= gscc_pkg::MaxCells)
			return 1'b0;
		if (!cell_written[addr])
			touched_unwritten = 1'b1;
		return cell_is_free[addr];
	endfunction

	function automatic bit endpoint_open(longint px, longint py);
		if (px < 0 || py < 0)
			return 1'b0;
		if (px >= grid_cols * OneCell || py >= grid_rows * OneCell)
			return 1'b0;
		return cell_open(px / OneCell, py / OneCell);
	endfunction

	// Supercover traversal, exact cross-product comparisons. A tie means the
	// line passes exactly through a corner: both side cells must be free.
	function automatic gscc_pkg::outcome_t walk_outcome(longint ax, longint ay,
			longint bx, longint by);
		longint x, y, ex, ey, dx, dy, sx, sy, adx, ady, nx, ny, lhs, rhs, limit;
		bit xdone, ydone, side_a, side_b;
		x = ax / OneCell;
		y = ay / OneCell;
		ex = bx / OneCell;
		ey = by / OneCell;
		dx = bx - ax;
		dy = by - ay;
		sx = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
		sy = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
		adx = (dx < 0) ? -dx : dx;
		ady = (dy < 0) ? -dy : dy;
		nx = 0;
		ny = 0;
		limit = grid_cols + grid_rows + 2;
		if (sx > 0) nx = (x + 1) * OneCell - ax;
		else if (sx < 0) nx = ax - x * OneCell;
		if (sy > 0) ny = (y + 1) * OneCell - ay;
		else if (sy < 0) ny = ay - y * OneCell;
		for (longint step = 0; step <= limit; step++) begin
			if (!cell_open(x, y))
				return gscc_pkg::OutBlocked;
			if (x == ex && y == ey)
				return gscc_pkg::OutClear;
			xdone = (sx == 0) || (x == ex);
			ydone = (sy == 0) || (y == ey);
			lhs = 0;
			rhs = 0;
			if (!xdone && !ydone) begin
				lhs = nx * ady;
				rhs = ny * adx;
			end
			if (!xdone && !ydone && lhs == rhs) begin
				// both sides evaluated so that the unwritten-read guard is conservative
				side_a = cell_open(x + sx, y);
				side_b = cell_open(x, y + sy);
				if (!side_a || !side_b)
					return gscc_pkg::OutBlocked;
				x += sx;
				y += sy;
				nx += OneCell;
				ny += OneCell;
			end else if (!xdone && (ydone || lhs < rhs)) begin
				x += sx;
				nx += OneCell;
			end else begin
				y += sy;
				ny += OneCell;
			end
		end
		return gscc_pkg::OutBlocked;
	endfunction

	// Outcome of a segment query; unsafe is set when the block would have to
	// read a map entry that was never written.
	function automatic gscc_pkg::outcome_t segment_outcome(gscc_pkg::req_t it,
			output bit unsafe);
		longint ax, ay, bx, by;
		bit a_ok, b_ok;
		gscc_pkg::outcome_t res;
		ax = longint'(it.from_x);
		ay = longint'(it.from_y);
		bx = longint'(it.to_x);
		by = longint'(it.to_y);
		touched_unwritten = 1'b0;
		a_ok = endpoint_open(ax, ay);
		b_ok = endpoint_open(bx, by);
		if (!a_ok || !b_ok)
			res = gscc_pkg::OutBadEnd;
		else
			res = walk_outcome(ax, ay, bx, by);
		unsafe = touched_unwritten;
		return res;
	endfunction

	// ---------------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_outcomes.size() == 0) begin
				report_mismatch($sformatf("outcome %0d with nothing expected",
					rsp_ch.data.outcome));
			end else begin
				gscc_pkg::outcome_t want;
				want = expected_outcomes.pop_front();
				if (rsp_ch.data.outcome !== want)
					report_mismatch($sformatf("outcome %0d, expected %0d",
						rsp_ch.data.outcome, want));
			end
		end
	end

	// Receiver: changes its stall habit after each stretch of random length;
	// one habit never stalls at all.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(32, 400);
			stall_mask = 8'($urandom_range(1, 255));
		end
		stall_left--;
		stall_phase++;
		case (stall_mode)
			0: begin
				rsp_ch.ready <= 1'b1;
			end
			1: begin
				rsp_ch.ready <= 1'($urandom_range(0, 1));
			end
			2: begin
				rsp_ch.ready <= ($urandom_range(0, 7) == 0);
			end
			default: begin
				rsp_ch.ready <= stall_mask[stall_phase[2:0]];
			end
		endcase
	end

	// ---------------------------------------------------------------------
	// Driving
	// ---------------------------------------------------------------------

	// Send one item. Bursts of random length; valid drops only between bursts,
	// and a new burst always starts after an idle gap of random length.
	task automatic send_item(gscc_pkg::req_t it);
		bit unsafe;
		gscc_pkg::outcome_t want;
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= it;
		do
			@(posedge clk);
		while (!req_ch.ready);
		// accepted: update our map state or work out the query outcome
		if (it.op == gscc_pkg::OpWrite) begin
			cell_is_free[it.cell_index] = (it.cost < gscc_pkg::BlockCost);
			cell_written[it.cell_index] = 1'b1;
			want = gscc_pkg::OutWrite;
		end else begin
			want = segment_outcome(it, unsafe);
		end
		expected_outcomes = {expected_outcomes, want};
		burst_left--;
		if (burst_left == 0)
			req_ch.valid <= 1'b0;
	endtask

	// Hold off until every expected outcome has come back.
	task automatic wait_idle();
		if (burst_left != 0) begin
			req_ch.valid <= 1'b0;
			burst_left = 0;
		end
		do
			@(posedge clk);
		while (expected_outcomes.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(logic idx, logic [12:0] value);
		longint v;
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		v = (value > gscc_pkg::MaxSide) ? gscc_pkg::MaxSide : value;
		if (idx == gscc_pkg::CfgColumns)
			grid_cols = v;
		else
			grid_rows = v;
	endtask

	task automatic write_cell(int unsigned idx, int unsigned cost);
		gscc_pkg::req_t it;
		it = '0;
		it.op = gscc_pkg::OpWrite;
		it.cell_index = 20'(idx);
		it.cost = 8'(cost);
		it.from_x = $urandom;
		it.from_y = $urandom;
		it.to_x = $urandom;
		it.to_y = $urandom;
		send_item(it);
	endtask

	function automatic gscc_pkg::req_t make_query(longint ax, longint ay,
			longint bx, longint by);
		gscc_pkg::req_t it;
		it.op = gscc_pkg::OpQuery;
		it.cell_index = 20'($urandom);
		it.cost = 8'($urandom);
		it.from_x = 32'(ax);
		it.from_y = 32'(ay);
		it.to_x = 32'(bx);
		it.to_y = 32'(by);
		return it;
	endfunction

	function automatic int unsigned random_cost();
		if ($urandom_range(0, 3) != 0)
			return $urandom_range(0, 252);
		return $urandom_range(0, 1) ? $urandom_range(253, 255) : $urandom_range(0, 255);
	endfunction

	// One coordinate in a window of cells; aligned ones sit on cell borders,
	// the upper border of the window included.
	function automatic longint pick_coord(longint base, longint span, bit aligned);
		if (aligned)
			return (base + $urandom_range(0, 32'(span))) * OneCell;
		return base * OneCell + $urandom_range(0, 32'(span * OneCell - 1));
	endfunction

	// A random query, mostly inside the patch, retried until it stays on written
	// cells, else an off-grid one. With an empty patch only wild coordinates are used.
	task automatic random_query(longint x0, longint y0, longint w, longint h);
		gscc_pkg::req_t it;
		bit unsafe;
		gscc_pkg::outcome_t dummy;
		int unsigned kind;
		longint ax, ay, bx, by;
		for (int tries = 0; tries < 40; tries++) begin
			kind = $urandom_range(0, 99);
			if (w == 0 || h == 0 || kind < 8) begin
				ax = longint'(signed'(32'($urandom)));
				ay = longint'(signed'(32'($urandom)));
				bx = longint'(signed'(32'($urandom)));
				by = longint'(signed'(32'($urandom)));
			end else begin
				ax = pick_coord(x0, w, kind < 35);
				ay = pick_coord(y0, h, kind < 35);
				bx = pick_coord(x0, w, kind < 35);
				by = pick_coord(y0, h, kind < 35);
				if (kind >= 35 && kind < 45) begin
					bx = ax;
					by = ay;
				end else if (kind >= 45 && kind < 50) begin
					ax = -longint'($urandom_range(1, 32'(OneCell)));
				end else if (kind >= 50 && kind < 58) begin
					// exact diagonal from a corner: rising ones cross only corners
					ax = pick_coord(x0, w - 1, 1'b1);
					ay = pick_coord(y0, h - 1, 1'b1);
					bx = ax + OneCell * $urandom_range(0, 3);
					by = ay + ((bx - ax) * ($urandom_range(0, 1) ? 1 : -1));
				end
			end
			it = make_query(ax, ay, bx, by);
			dummy = segment_outcome(it, unsafe);
			if (!unsafe) begin
				send_item(it);
				return;
			end
		end
		send_item(make_query(-1, 0, 0, 0));
	endtask

	task automatic random_write(longint x0, longint y0, longint w, longint h);
		longint addr;
		if (w != 0 && h != 0 && $urandom_range(0, 9) < 7) begin
			addr = (y0 + $urandom_range(0, 32'(h - 1))) * grid_cols + x0
				+ $urandom_range(0, 32'(w - 1));
			if (addr < gscc_pkg::MaxCells) begin
				write_cell(32'(addr), random_cost());
				return;
			end
		end
		write_cell($urandom_range(0, gscc_pkg::MaxCells - 1), random_cost());
	endtask

	// Set the grid, fill a patch of cells, then mix random writes and queries
	// over it, with one full drain half way through.
	task automatic run_phase(logic [12:0] cols, logic [12:0] rows,
			longint x0, longint y0, longint w, longint h, int n);
		longint addr;
		wait_idle();
		write_register(gscc_pkg::CfgColumns, cols);
		write_register(gscc_pkg::CfgRows, rows);
		for (longint y = y0; y < y0 + h; y++)
			for (longint x = x0; x < x0 + w; x++) begin
				addr = y * grid_cols + x;
				if (addr < gscc_pkg::MaxCells)
					write_cell(32'(addr), ($urandom_range(0, 4) == 0)
						? $urandom_range(253, 255) : $urandom_range(0, 252));
			end
		for (int i = 0; i < n; i++) begin
			if (i == n / 2)
				wait_idle();
			if ($urandom_range(0, 9) == 0)
				random_write(x0, y0, w, h);
			else
				random_query(x0, y0, w, h);
		end
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Reset grid of 3 by 3. Row 1 has both outer cells blocked, so corner
	// crossings around the centre have exactly one blocked side.
	task automatic test_small_grid_directed();
		for (int i = 0; i < 9; i++)
			write_cell(i, (i == 5) ? 253 : (i == 3) ? 255 : (i == 1) ? 252 : 0);
		write_cell(gscc_pkg::MaxCells - 1, 170);
		send_item(make_query(OneCell / 2, OneCell / 2, OneCell / 2, OneCell / 2));
		send_item(make_query(OneCell / 2, OneCell / 2, 5 * OneCell / 2, OneCell / 2));
		send_item(make_query(OneCell / 2, OneCell / 2, OneCell / 2, 5 * OneCell / 2));
		send_item(make_query(OneCell / 2, 3 * OneCell / 2, OneCell / 2, OneCell / 2));
		send_item(make_query(OneCell / 2, OneCell / 2, 3 * OneCell / 2, 3 * OneCell / 2));
		send_item(make_query(3 * OneCell / 2, 3 * OneCell / 2, 5 * OneCell / 2, 5 * OneCell / 2));
		send_item(make_query(5 * OneCell / 2, OneCell / 2, 3 * OneCell / 2, 3 * OneCell / 2));
		send_item(make_query(0, 0, 3 * OneCell - 1, 0));
		send_item(make_query(0, 2 * OneCell, 3 * OneCell - 1, 3 * OneCell - 1));
		send_item(make_query(-1, 0, OneCell, OneCell));
		send_item(make_query(0, 0, 3 * OneCell, 0));
		send_item(make_query(0, 0, 0, 3 * OneCell));
		send_item(make_query(32'h7FFF_FFFF, 0, 0, 0));
		send_item(make_query(0, 0, -longint'(32'h8000_0000), -longint'(32'h8000_0000)));
		send_item(make_query(2 * OneCell, 0, 0, 2 * OneCell + OneCell - 1));
	endtask

	// Zero-sized grids: nothing is inside, every query must come back outside.
	task automatic test_degenerate_grid();
		run_phase(13'd0, 13'd7, 0, 0, 0, 0, 30);
		run_phase(13'd7, 13'd0, 0, 0, 0, 0, 30);
	endtask

	// Largest grid: columns written above the cap to check saturation. The
	// patch straddles the row where addresses run past the end of the store.
	task automatic test_large_grid();
		run_phase(13'h1FFF, 13'd4096, 4090, 253, 6, 6, 200);
		run_phase(13'd4096, 13'd3, 0, 0, 10, 3, 220);
		run_phase(13'd5, 13'd4096, 0, 4088, 5, 8, 220);
	endtask

	task automatic test_random_grids();
		run_phase(13'd8, 13'd8, 0, 0, 8, 8, 150);
		run_phase(13'd3, 13'd3, 0, 0, 3, 3, 180);
		run_phase(13'd16, 13'd5, 0, 0, 16, 5, 250);
		run_phase(13'd100, 13'd60, 40, 20, 10, 10, 250);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = 1'b0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		grid_cols = 3;
		grid_rows = 3;
		failures = 0;
		burst_left = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_small_grid_directed();
		test_random_grids();
		test_large_grid();
		test_degenerate_grid();

		wait_idle();
		repeat (20) @(posedge clk);
		if (failures == 0 && expected_outcomes.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			if (expected_outcomes.size() != 0)
				report_mismatch($sformatf("%0d outcomes never arrived",
					expected_outcomes.size()));
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
